// ----- rtl/crdg_pkg.sv -----
// Shared widths, types and register codes for the camera ray direction generator.
`default_nettype none
package crdg_pkg;

	localparam int REG_W   = 63;   // packed x,y,z register
	localparam int FIELD_W = 21;   // one Q11.10 component
	localparam int CFG_IDX_W = 2;
	localparam int PIX_W   = 10;
	localparam int IDX_W   = 20;
	localparam int DIFF_W  = FIELD_W + 1;
	localparam int DIM_W   = 14;   // signed screen dimension up to 8191
	localparam int WH_W    = 27;   // signed width*height
	localparam int BX_W    = DIFF_W + PIX_W + 1;
	localparam int D_W     = 49;   // exact scaled direction component
	localparam int MAG_W   = 48;
	localparam int POS_W   = $clog2(MAG_W);
	localparam int NRM_W   = 31;   // normalized magnitude, msb at bit 30
	localparam int SQ_W    = 2 * NRM_W;
	localparam int SUM_W   = 64;
	localparam int LEN_W   = 32;
	localparam int REM_W   = LEN_W + 3;
	localparam int FRAC_W  = 14;
	localparam int NUM_W   = NRM_W + FRAC_W + 1;
	localparam int Q_W     = FRAC_W + 1;
	localparam int DIR_W   = 16;

	localparam int SCREEN_WIDTH_DEF  = 1024;
	localparam int SCREEN_HEIGHT_DEF = 768;

	localparam logic [Q_W-1:0] Q_ONE = Q_W'(1 << FRAC_W);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TOP_LEFT,
		REG_TOP_RIGHT,
		REG_BOTTOM_LEFT,
		REG_CAMERA
	} reg_idx_t;

	typedef struct packed {
		logic [REG_W-1:0] tl;
		logic [REG_W-1:0] tr;
		logic [REG_W-1:0] bl;
		logic [REG_W-1:0] cp;
	} cam_t;

	// sideband that rides along the sqrt and divide stages
	typedef struct packed {
		logic [IDX_W-1:0]            idx;
		logic [2:0]                  neg;
		logic                        zero;
		logic [2:0][NRM_W-1:0]       nm;
	} side_t;

endpackage
`default_nettype wire

// ----- rtl/crdg_front.sv -----
// Screen point minus eye, exact and scaled by width*height, then sign and magnitude.
`default_nettype none
module crdg_front #(
	parameter int SCREEN_WIDTH  = crdg_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = crdg_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    en,
	input  logic                                    in_valid,
	input  logic [crdg_pkg::PIX_W-1:0]              pixel_x,
	input  logic [crdg_pkg::PIX_W-1:0]              pixel_y,
	input  crdg_pkg::cam_t                          cam,
	output logic                                    out_valid,
	output logic [2:0][crdg_pkg::MAG_W-1:0]         mag,
	output logic [2:0]                              neg,
	output logic [crdg_pkg::IDX_W-1:0]              idx
);

	localparam logic signed [crdg_pkg::DIM_W-1:0] H_S = crdg_pkg::DIM_W'(SCREEN_HEIGHT);
	localparam logic signed [crdg_pkg::DIM_W-1:0] W_S = crdg_pkg::DIM_W'(SCREEN_WIDTH);
	localparam logic signed [crdg_pkg::WH_W-1:0] WH_S =
		crdg_pkg::WH_W'(SCREEN_WIDTH * SCREEN_HEIGHT);
	localparam logic [crdg_pkg::IDX_W-1:0] W_IDX = crdg_pkg::IDX_W'(SCREEN_WIDTH);

	function automatic logic signed [crdg_pkg::DIFF_W-1:0] unpack(
		input logic [crdg_pkg::REG_W-1:0] r,
		input int c
	);
		logic signed [crdg_pkg::FIELD_W-1:0] f;
		f = $signed(r[c*crdg_pkg::FIELD_W +: crdg_pkg::FIELD_W]);
		return crdg_pkg::DIFF_W'(f);
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [crdg_pkg::DIFF_W-1:0] dtc_s1 [3];
	logic signed [crdg_pkg::DIFF_W-1:0] ex_s1 [3];
	logic signed [crdg_pkg::DIFF_W-1:0] ey_s1 [3];
	logic [crdg_pkg::PIX_W-1:0] px_s1, py_s1;
	logic [crdg_pkg::IDX_W-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic signed [crdg_pkg::D_W-1:0] a_s2 [3];
	logic signed [crdg_pkg::BX_W-1:0] bx_s2 [3];
	logic signed [crdg_pkg::BX_W-1:0] by_s2 [3];
	logic signed [crdg_pkg::D_W-1:0] a_s3 [3];
	logic signed [crdg_pkg::D_W-1:0] cx_s3 [3];
	logic signed [crdg_pkg::D_W-1:0] cy_s3 [3];
	logic signed [crdg_pkg::D_W-1:0] d_s4 [3];
	logic [2:0][crdg_pkg::MAG_W-1:0] mag_s5;
	logic [2:0] neg_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1  <= pixel_x;
			py_s1  <= pixel_y;
			idx_s1 <= crdg_pkg::IDX_W'(pixel_y * W_IDX) + crdg_pkg::IDX_W'(pixel_x);
			idx_s2 <= idx_s1;
			idx_s3 <= idx_s2;
			idx_s4 <= idx_s3;
			idx_s5 <= idx_s4;
			for (int c = 0; c < 3; c++) begin
				dtc_s1[c] <= unpack(cam.tl, c) - unpack(cam.cp, c);
				ex_s1[c]  <= unpack(cam.tr, c) - unpack(cam.tl, c);
				ey_s1[c]  <= unpack(cam.bl, c) - unpack(cam.tl, c);
				a_s2[c]   <= dtc_s1[c] * WH_S;
				bx_s2[c]  <= ex_s1[c] * $signed({1'b0, px_s1});
				by_s2[c]  <= ey_s1[c] * $signed({1'b0, py_s1});
				a_s3[c]   <= a_s2[c];
				cx_s3[c]  <= bx_s2[c] * H_S;
				cy_s3[c]  <= by_s2[c] * W_S;
				d_s4[c]   <= a_s3[c] + cx_s3[c] + cy_s3[c];
				neg_s5[c] <= d_s4[c][crdg_pkg::D_W-1];
				mag_s5[c] <= d_s4[c][crdg_pkg::D_W-1] ? crdg_pkg::MAG_W'(-d_s4[c])
				                                       : crdg_pkg::MAG_W'(d_s4[c]);
			end
		end
	end

	assign out_valid = v_s5;
	assign mag       = mag_s5;
	assign neg       = neg_s5;
	assign idx       = idx_s5;

endmodule
`default_nettype wire

// ----- rtl/crdg_norm.sv -----
// Common shift that brings the largest of the three magnitudes into [2^30, 2^31), and sum of squares.
`default_nettype none
module crdg_norm (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic [2:0][crdg_pkg::MAG_W-1:0]     mag,
	input  logic [2:0]                          neg,
	input  logic [crdg_pkg::IDX_W-1:0]          idx,
	output logic                                out_valid,
	output crdg_pkg::side_t                     side,
	output logic [crdg_pkg::SUM_W-1:0]          sum
);

	localparam logic [crdg_pkg::POS_W-1:0] TOP_POS = crdg_pkg::POS_W'(crdg_pkg::NRM_W - 1);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [crdg_pkg::MAG_W-1:0] m_c, m_s1;
	logic [2:0][crdg_pkg::MAG_W-1:0] mag_s1, mag_s2;
	logic [2:0] neg_s1, neg_s2;
	logic [crdg_pkg::IDX_W-1:0] idx_s1, idx_s2;
	logic [crdg_pkg::POS_W-1:0] pos_c, pos_s2;
	logic zero_s2;
	logic [2:0][crdg_pkg::NRM_W-1:0] nm_c;
	crdg_pkg::side_t side_s3, side_s4, side_s5;
	logic [crdg_pkg::SQ_W-1:0] sq_s4 [3];
	logic [crdg_pkg::SUM_W-1:0] sum_s5;

	always_comb begin
		m_c = mag[0];
		if (mag[1] > m_c) m_c = mag[1];
		if (mag[2] > m_c) m_c = mag[2];
	end

	// msb position of the largest magnitude
	always_comb begin
		pos_c = '0;
		for (int i = 0; i < crdg_pkg::MAG_W; i++) begin
			if (m_s1[i]) pos_c = crdg_pkg::POS_W'(i);
		end
	end

	always_comb begin
		logic [crdg_pkg::MAG_W-1:0] t;
		for (int c = 0; c < 3; c++) begin
			if (pos_s2 >= TOP_POS) begin
				t = mag_s2[c] >> (pos_s2 - TOP_POS);
			end else begin
				t = mag_s2[c] << (TOP_POS - pos_s2);
			end
			nm_c[c] = t[crdg_pkg::NRM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1         <= m_c;
			mag_s1       <= mag;
			neg_s1       <= neg;
			idx_s1       <= idx;
			pos_s2       <= pos_c;
			zero_s2      <= (m_s1 == '0);
			mag_s2       <= mag_s1;
			neg_s2       <= neg_s1;
			idx_s2       <= idx_s1;
			side_s3.idx  <= idx_s2;
			side_s3.neg  <= neg_s2;
			side_s3.zero <= zero_s2;
			side_s3.nm   <= nm_c;
			for (int c = 0; c < 3; c++) begin
				sq_s4[c] <= side_s3.nm[c] * side_s3.nm[c];
			end
			side_s4 <= side_s3;
			sum_s5  <= crdg_pkg::SUM_W'(sq_s4[0]) + crdg_pkg::SUM_W'(sq_s4[1])
			         + crdg_pkg::SUM_W'(sq_s4[2]);
			side_s5 <= side_s4;
		end
	end

	assign out_valid = v_s5;
	assign side      = side_s5;
	assign sum       = sum_s5;

endmodule
`default_nettype wire

// ----- rtl/crdg_sqrt.sv -----
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module crdg_sqrt (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  crdg_pkg::side_t                 side_in,
	input  logic [crdg_pkg::SUM_W-1:0]      sum,
	output logic                            out_valid,
	output crdg_pkg::side_t                 side_out,
	output logic [crdg_pkg::LEN_W-1:0]      len
);

	localparam int N = crdg_pkg::LEN_W;

	logic                           v_s    [N];
	crdg_pkg::side_t                side_s [N];
	logic [crdg_pkg::REM_W-1:0]     rem_s  [N];
	logic [crdg_pkg::LEN_W-1:0]     root_s [N];
	logic [crdg_pkg::SUM_W-1:0]     rad_s  [N];
	logic [crdg_pkg::REM_W-1:0]     rem_n  [N];
	logic [crdg_pkg::LEN_W-1:0]     root_n [N];
	logic [crdg_pkg::SUM_W-1:0]     rad_n  [N];

	always_comb begin
		logic [crdg_pkg::REM_W-1:0] rp;
		logic [crdg_pkg::REM_W-1:0] rc;
		logic [crdg_pkg::REM_W-1:0] tr;
		logic [crdg_pkg::LEN_W-1:0] qp;
		logic [crdg_pkg::SUM_W-1:0] dp;
		for (int k = 0; k < N; k++) begin
			if (k == 0) begin
				rp = '0;
				qp = '0;
				dp = sum;
			end else begin
				rp = rem_s[k-1];
				qp = root_s[k-1];
				dp = rad_s[k-1];
			end
			// bring down the next two radicand bits, try root*4+1
			rc = {rp[crdg_pkg::REM_W-3:0], dp[crdg_pkg::SUM_W-1 -: 2]};
			tr = crdg_pkg::REM_W'({qp, 2'b01});
			if (rc >= tr) begin
				rem_n[k]  = rc - tr;
				root_n[k] = {qp[crdg_pkg::LEN_W-2:0], 1'b1};
			end else begin
				rem_n[k]  = rc;
				root_n[k] = {qp[crdg_pkg::LEN_W-2:0], 1'b0};
			end
			rad_n[k] = dp << 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) v_s[k] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int k = 1; k < N; k++) v_s[k] <= v_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			for (int k = 1; k < N; k++) side_s[k] <= side_s[k-1];
			for (int k = 0; k < N; k++) begin
				rem_s[k]  <= rem_n[k];
				root_s[k] <= root_n[k];
				rad_s[k]  <= rad_n[k];
			end
		end
	end

	assign out_valid = v_s[N-1];
	assign side_out  = side_s[N-1];
	assign len       = root_s[N-1];

endmodule
`default_nettype wire

// ----- rtl/crdg_div.sv -----
// Three-lane pipelined rounding divide by the length, then saturate and apply sign.
`default_nettype none
module crdg_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  crdg_pkg::side_t                     side_in,
	input  logic [crdg_pkg::LEN_W-1:0]          len,
	output logic                                out_valid,
	output logic [crdg_pkg::IDX_W-1:0]          idx,
	output logic [2:0][crdg_pkg::DIR_W-1:0]     dir,
	output logic                                zero
);

	localparam int N = crdg_pkg::Q_W;

	logic                                   v_s0;
	crdg_pkg::side_t                        side_s0;
	logic [crdg_pkg::LEN_W-1:0]             len_s0;
	logic [2:0][crdg_pkg::NUM_W-1:0]        num_s0;

	logic                                   v_s    [N];
	crdg_pkg::side_t                        side_s [N];
	logic [crdg_pkg::LEN_W-1:0]             len_s  [N];
	logic [2:0][crdg_pkg::NUM_W-1:0]        rem_s  [N];
	logic [2:0][crdg_pkg::Q_W-1:0]          quo_s  [N];
	logic [2:0][crdg_pkg::NUM_W-1:0]        rem_n  [N];
	logic [2:0][crdg_pkg::Q_W-1:0]          quo_n  [N];

	logic                                   v_q;
	logic [crdg_pkg::IDX_W-1:0]             idx_q;
	logic [2:0][crdg_pkg::DIR_W-1:0]        dir_q;
	logic                                   zero_q;
	logic [2:0][crdg_pkg::DIR_W-1:0]        dir_c;

	// restoring division, quotient msb first
	always_comb begin
		logic [crdg_pkg::NUM_W-1:0] rp;
		logic [crdg_pkg::NUM_W-1:0] dvs;
		logic [crdg_pkg::Q_W-1:0]   qp;
		logic [crdg_pkg::LEN_W-1:0] lp;
		for (int j = 0; j < N; j++) begin
			lp = (j == 0) ? len_s0 : len_s[j-1];
			dvs = crdg_pkg::NUM_W'(lp) << (N - 1 - j);
			for (int c = 0; c < 3; c++) begin
				if (j == 0) begin
					rp = num_s0[c];
					qp = '0;
				end else begin
					rp = rem_s[j-1][c];
					qp = quo_s[j-1][c];
				end
				if (rp >= dvs) begin
					rem_n[j][c] = rp - dvs;
					quo_n[j][c] = {qp[crdg_pkg::Q_W-2:0], 1'b1};
				end else begin
					rem_n[j][c] = rp;
					quo_n[j][c] = {qp[crdg_pkg::Q_W-2:0], 1'b0};
				end
			end
		end
	end

	always_comb begin
		logic [crdg_pkg::Q_W-1:0]   qs;
		logic [crdg_pkg::DIR_W-1:0] mg;
		for (int c = 0; c < 3; c++) begin
			qs = (quo_s[N-1][c] > crdg_pkg::Q_ONE) ? crdg_pkg::Q_ONE : quo_s[N-1][c];
			mg = crdg_pkg::DIR_W'(qs);
			if (side_s[N-1].zero) begin
				dir_c[c] = '0;
			end else if (side_s[N-1].neg[c]) begin
				dir_c[c] = -mg;
			end else begin
				dir_c[c] = mg;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
			for (int j = 0; j < N; j++) v_s[j] <= 1'b0;
			v_q <= 1'b0;
		end else if (en) begin
			v_s0 <= in_valid;
			v_s[0] <= v_s0;
			for (int j = 1; j < N; j++) v_s[j] <= v_s[j-1];
			v_q <= v_s[N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s0 <= side_in;
			len_s0  <= len;
			for (int c = 0; c < 3; c++) begin
				// numerator nm * 2^14 + floor(len/2) for round to nearest
				num_s0[c] <= crdg_pkg::NUM_W'({side_in.nm[c], {crdg_pkg::FRAC_W{1'b0}}})
				           + crdg_pkg::NUM_W'(len[crdg_pkg::LEN_W-1:1]);
			end
			side_s[0] <= side_s0;
			len_s[0]  <= len_s0;
			for (int j = 1; j < N; j++) begin
				side_s[j] <= side_s[j-1];
				len_s[j]  <= len_s[j-1];
			end
			for (int j = 0; j < N; j++) begin
				rem_s[j] <= rem_n[j];
				quo_s[j] <= quo_n[j];
			end
			idx_q  <= side_s[N-1].idx;
			zero_q <= side_s[N-1].zero;
			dir_q  <= dir_c;
		end
	end

	assign out_valid = v_q;
	assign idx       = idx_q;
	assign dir       = dir_q;
	assign zero      = zero_q;

endmodule
`default_nettype wire

// ----- rtl/camera_ray_direction_generator_unit.sv -----
// Top level: config registers, pipeline enable and the four pipeline sections.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------------------
//  pix      | pix_valid / pix_stall | pixel_x, pixel_y
//  ray      | ray_valid / ray_stall | pixel_index, dir_x, dir_y, dir_z, zero_length
//  cfg      | cfg_we                | cfg_index, cfg_data
//
//  One beat per cycle in and one per cycle out while ray_stall does not hold the output;
//  each beat passes the point, normalize, square root and divide-and-output sections in turn.
//  The square root and divide stages, one result bit each, set the depth.
//  A stalled output beat freezes the whole pipeline; pix_stall follows it.
//  Reset clears valid bits and the four registers to zero.
`default_nettype none
module camera_ray_direction_generator_unit #(
	parameter int SCREEN_WIDTH  = crdg_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = crdg_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pix_valid,
	output logic                                pix_stall,
	input  logic [crdg_pkg::PIX_W-1:0]          pixel_x,
	input  logic [crdg_pkg::PIX_W-1:0]          pixel_y,
	output logic                                ray_valid,
	input  logic                                ray_stall,
	output logic [crdg_pkg::IDX_W-1:0]          pixel_index,
	output logic signed [crdg_pkg::DIR_W-1:0]   dir_x,
	output logic signed [crdg_pkg::DIR_W-1:0]   dir_y,
	output logic signed [crdg_pkg::DIR_W-1:0]   dir_z,
	output logic                                zero_length,
	input  logic                                cfg_we,
	input  logic [crdg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [crdg_pkg::REG_W-1:0]          cfg_data
);

	crdg_pkg::cam_t cam_q;
	logic en;

	logic                                   fr_valid;
	logic [2:0][crdg_pkg::MAG_W-1:0]        fr_mag;
	logic [2:0]                             fr_neg;
	logic [crdg_pkg::IDX_W-1:0]             fr_idx;
	logic                                   nr_valid;
	crdg_pkg::side_t                        nr_side;
	logic [crdg_pkg::SUM_W-1:0]             nr_sum;
	logic                                   sq_valid;
	crdg_pkg::side_t                        sq_side;
	logic [crdg_pkg::LEN_W-1:0]             sq_len;
	logic [2:0][crdg_pkg::DIR_W-1:0]        dv_dir;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q <= '0;
		end else if (cfg_we) begin
			case (crdg_pkg::reg_idx_t'(cfg_index))
				crdg_pkg::REG_TOP_LEFT:    cam_q.tl <= cfg_data;
				crdg_pkg::REG_TOP_RIGHT:   cam_q.tr <= cfg_data;
				crdg_pkg::REG_BOTTOM_LEFT: cam_q.bl <= cfg_data;
				crdg_pkg::REG_CAMERA:      cam_q.cp <= cfg_data;
				default:                   cam_q    <= cam_q;
			endcase
		end
	end

	assign en        = !ray_valid || !ray_stall;
	assign pix_stall = !en;

	crdg_front #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (pix_valid),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.cam       (cam_q),
		.out_valid (fr_valid),
		.mag       (fr_mag),
		.neg       (fr_neg),
		.idx       (fr_idx)
	);

	crdg_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.mag       (fr_mag),
		.neg       (fr_neg),
		.idx       (fr_idx),
		.out_valid (nr_valid),
		.side      (nr_side),
		.sum       (nr_sum)
	);

	crdg_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (nr_valid),
		.side_in   (nr_side),
		.sum       (nr_sum),
		.out_valid (sq_valid),
		.side_out  (sq_side),
		.len       (sq_len)
	);

	crdg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.side_in   (sq_side),
		.len       (sq_len),
		.out_valid (ray_valid),
		.idx       (pixel_index),
		.dir       (dv_dir),
		.zero      (zero_length)
	);

	assign dir_x = $signed(dv_dir[0]);
	assign dir_y = $signed(dv_dir[1]);
	assign dir_z = $signed(dv_dir[2]);

	a_zero_dir: assert property (@(posedge clk) disable iff (!arst_n)
		ray_valid && zero_length |-> dir_x == '0 && dir_y == '0 && dir_z == '0)
		else $error("zero-length beat carries a nonzero direction");

	a_nonzero_dir: assert property (@(posedge clk) disable iff (!arst_n)
		ray_valid && !zero_length |-> dir_x != '0 || dir_y != '0 || dir_z != '0)
		else $error("nonzero vector normalized to all-zero direction");

	a_dir_range: assert property (@(posedge clk) disable iff (!arst_n)
		ray_valid |-> dir_x >= -16384 && dir_x <= 16384 && dir_y >= -16384
		&& dir_y <= 16384 && dir_z >= -16384 && dir_z <= 16384)
		else $error("direction component beyond unit range");

endmodule
`default_nettype wire

// ----- bench/camera_ray_direction_generator_unit_tb.sv -----
// Self-checking testbench for the camera ray direction generator: directed table, then random.
`default_nettype none
module camera_ray_direction_generator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW = crdg_pkg::SCREEN_WIDTH_DEF;
	localparam int SH = crdg_pkg::SCREEN_HEIGHT_DEF;
	localparam int DRAIN_CYCLES = 80;

	typedef struct {
		logic [crdg_pkg::IDX_W-1:0] idx;
		logic [crdg_pkg::DIR_W-1:0] dx;
		logic [crdg_pkg::DIR_W-1:0] dy;
		logic [crdg_pkg::DIR_W-1:0] dz;
		logic                       zero;
	} ray_t;

	typedef struct {
		logic [crdg_pkg::PIX_W-1:0] px;
		logic [crdg_pkg::PIX_W-1:0] py;
		logic [crdg_pkg::IDX_W-1:0] idx;
	} pix_row_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                pix_valid = 1'b0;
	logic                                pix_stall;
	logic [crdg_pkg::PIX_W-1:0]          pixel_x = '0;
	logic [crdg_pkg::PIX_W-1:0]          pixel_y = '0;
	logic                                ray_valid;
	logic                                ray_stall = 1'b0;
	logic [crdg_pkg::IDX_W-1:0]          pixel_index;
	logic signed [crdg_pkg::DIR_W-1:0]   dir_x, dir_y, dir_z;
	logic                                zero_length;
	logic                                cfg_we = 1'b0;
	logic [crdg_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
	logic [crdg_pkg::REG_W-1:0]          cfg_data = '0;

	logic [crdg_pkg::REG_W-1:0] cam_regs [4];
	ray_t ray_q [$];
	int   fail_cnt = 0;
	bit   quiet_in = 0;
	bit   quiet_out = 0;

	camera_ray_direction_generator_unit DUT (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("camera_ray_direction_generator_unit verification failed");
		$finish;
	end

	function automatic longint comp_of(logic [crdg_pkg::REG_W-1:0] r, int c);
		logic signed [crdg_pkg::FIELD_W-1:0] f;
		f = r[c*crdg_pkg::FIELD_W +: crdg_pkg::FIELD_W];
		return longint'(f);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic ray_t predict_ray(logic [crdg_pkg::PIX_W-1:0] px,
			logic [crdg_pkg::PIX_W-1:0] py);
		ray_t r;
		longint tl, ex, ey, cp, d;
		longint unsigned mag [3];
		bit neg [3];
		longint unsigned m, s, len, q;
		logic [crdg_pkg::DIR_W-1:0] v [3];
		m = 0;
		for (int c = 0; c < 3; c++) begin
			tl = comp_of(cam_regs[crdg_pkg::REG_TOP_LEFT], c);
			ex = comp_of(cam_regs[crdg_pkg::REG_TOP_RIGHT], c) - tl;
			ey = comp_of(cam_regs[crdg_pkg::REG_BOTTOM_LEFT], c) - tl;
			cp = comp_of(cam_regs[crdg_pkg::REG_CAMERA], c);
			d = (tl - cp) * SW * SH + ex * longint'(px) * SH + ey * longint'(py) * SW;
			neg[c] = d < 0;
			mag[c] = neg[c] ? -d : d;
			if (mag[c] > m) m = mag[c];
		end
		r.idx = crdg_pkg::IDX_W'(longint'(px) + longint'(py) * SW);
		r.zero = (m == 0);
		r.dx = '0; r.dy = '0; r.dz = '0;
		if (m != 0) begin
			while (m < (64'd1 << 30)) begin
				for (int c = 0; c < 3; c++) mag[c] <<= 1;
				m <<= 1;
			end
			while (m >= (64'd1 << 31)) begin
				for (int c = 0; c < 3; c++) mag[c] >>= 1;
				m >>= 1;
			end
			s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
			len = int_sqrt(s);
			for (int c = 0; c < 3; c++) begin
				q = (mag[c] * 16384 + (len >> 1)) / len;
				if (q > 16384) q = 16384;
				v[c] = neg[c] ? crdg_pkg::DIR_W'(-q) : crdg_pkg::DIR_W'(q);
			end
			r.dx = v[0]; r.dy = v[1]; r.dz = v[2];
		end
		return r;
	endfunction

	function automatic int pick_gap(bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [crdg_pkg::FIELD_W-1:0] rand_field();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return 21'h100000;
			1: return 21'h0FFFFF;
			2: return '0;
			3, 4, 5: return crdg_pkg::FIELD_W'($urandom_range(0, 4096) - 2048);
			default: return crdg_pkg::FIELD_W'($urandom);
		endcase
	endfunction

	function automatic logic [crdg_pkg::REG_W-1:0] pack3(int x, int y, int z);
		return {crdg_pkg::FIELD_W'(z), crdg_pkg::FIELD_W'(y), crdg_pkg::FIELD_W'(x)};
	endfunction

	// called at a falling edge while the pipeline is empty
	task automatic write_reg(crdg_pkg::reg_idx_t i, logic [crdg_pkg::REG_W-1:0] v);
		cfg_we = 1'b1;
		cfg_index = i;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
		cam_regs[i] = v;
	endtask

	task automatic write_cam(logic [crdg_pkg::REG_W-1:0] tl, logic [crdg_pkg::REG_W-1:0] tr,
			logic [crdg_pkg::REG_W-1:0] bl, logic [crdg_pkg::REG_W-1:0] cp);
		write_reg(crdg_pkg::REG_TOP_LEFT, tl);
		write_reg(crdg_pkg::REG_TOP_RIGHT, tr);
		write_reg(crdg_pkg::REG_BOTTOM_LEFT, bl);
		write_reg(crdg_pkg::REG_CAMERA, cp);
	endtask

	// starts and ends at a falling edge; valid stays high across back-to-back beats
	task automatic send_pixel(logic [crdg_pkg::PIX_W-1:0] px, logic [crdg_pkg::PIX_W-1:0] py,
			ray_t want);
		int gap;
		gap = pick_gap(quiet_in);
		if (gap > 0) begin
			pix_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pixel_x = px;
		pixel_y = py;
		pix_valid = 1'b1;
		do @(posedge clk); while (pix_stall);
		ray_q.push_back(want);
		@(negedge clk);
	endtask

	task automatic drain();
		pix_valid = 1'b0;
		while (ray_q.size() != 0) @(negedge clk);
	endtask

	// result checker and output stall generator
	initial begin
		ray_t e;
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (arst_n && ray_valid && !ray_stall) begin
				if (ray_q.size() == 0) begin
					$display("%0t: unexpected beat idx=%0d", $time, pixel_index);
					fail_cnt++;
				end else begin
					e = ray_q.pop_front();
					if (pixel_index !== e.idx || dir_x !== e.dx || dir_y !== e.dy ||
							dir_z !== e.dz || zero_length !== e.zero) begin
						$display("%0t: mismatch exp idx=%0d x=%0d y=%0d z=%0d zero=%0b",
							$time, e.idx, $signed(e.dx), $signed(e.dy), $signed(e.dz), e.zero);
						$display("%0t:          got idx=%0d x=%0d y=%0d z=%0d zero=%0b",
							$time, pixel_index, dir_x, dir_y, dir_z, zero_length);
						fail_cnt++;
					end
				end
			end
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				ray_stall = 1'b1;
			end else begin
				hold = pick_gap(quiet_out);
				ray_stall = hold > 0;
				if (hold > 0) hold--;
			end
		end
	end

	pix_row_t pix_table [6] = '{
		'{10'd0,    10'd0,    20'd0},
		'{10'd1023, 10'd1023, 20'd1048575},
		'{10'd1023, 10'd767,  20'd786431},
		'{10'd512,  10'd384,  20'd393728},
		'{10'h155,  10'h2AA,  20'd698709},
		'{10'h2AA,  10'h155,  20'd349866}
	};

	initial begin
		ray_t want;
		logic [crdg_pkg::PIX_W-1:0] px, py;
		logic [crdg_pkg::REG_W-1:0] tl;
		for (int i = 0; i < 4; i++) cam_regs[i] = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// registers at reset: every point sits on the camera
		foreach (pix_table[i]) begin
			want = '{pix_table[i].idx, 16'd0, 16'd0, 16'd0, 1'b1};
			send_pixel(pix_table[i].px, pix_table[i].py, want);
		end

		for (int k = 0; k < 3; k++) begin
			drain();
			case (k)
				0: write_cam(pack3(-1024, 768, -1024), pack3(1024, 768, -1024),
					pack3(-1024, -768, -1024), pack3(0, 0, 0));
				// full-scale extremes, long edge vectors
				1: write_cam(pack3(32'hFFFFF, 32'hFFFFF, 32'hFFFFF),
					pack3(-32'h100000, -32'h100000, -32'h100000),
					pack3(-32'h100000, 32'hFFFFF, -32'h100000),
					pack3(-32'h100000, -32'h100000, 32'hFFFFF));
				// camera on the top-left corner: pixel 0,0 has no direction
				default: write_cam(pack3(5, -7, 300), pack3(900, -7, 300),
					pack3(5, -600, 301), pack3(5, -7, 300));
			endcase
			foreach (pix_table[i])
				send_pixel(pix_table[i].px, pix_table[i].py,
					predict_ray(pix_table[i].px, pix_table[i].py));
		end

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			quiet_in = (ph == 2);
			quiet_out = (ph == 2 || ph == 5);
			tl = {rand_field(), rand_field(), rand_field()};
			write_cam(tl, {rand_field(), rand_field(), rand_field()},
				{rand_field(), rand_field(), rand_field()},
				(ph % 3 == 1) ? tl : {rand_field(), rand_field(), rand_field()});
			for (int n = 0; n < 78; n++) begin
				if (ph == 3 && n == 40) drain();
				if ($urandom_range(0, 19) == 0) begin
					px = '0;
					py = '0;
				end else if ($urandom_range(0, 99) < 85) begin
					px = crdg_pkg::PIX_W'($urandom_range(0, SW - 1));
					py = crdg_pkg::PIX_W'($urandom_range(0, SH - 1));
				end else begin
					px = crdg_pkg::PIX_W'($urandom);
					py = crdg_pkg::PIX_W'($urandom);
				end
				send_pixel(px, py, predict_ray(px, py));
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_cnt == 0 && ray_q.size() == 0)
			$display("camera_ray_direction_generator_unit verification clean");
		else
			$display("camera_ray_direction_generator_unit verification failed");
		$finish;
	end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/crdg_pkg.sv
rtl/crdg_front.sv
rtl/crdg_norm.sv
rtl/crdg_sqrt.sv
rtl/crdg_div.sv
rtl/camera_ray_direction_generator_unit.sv
bench/camera_ray_direction_generator_unit_tb.sv
